FILE: src/bptc_pkg.sv
// Package: widths, microcode field types and the control program for the compensation block.
package bptc_pkg;

    localparam int RAW_W     = 24;
    localparam int COEF_W    = 16;
    localparam int TEMP_W    = 19;
    localparam int PRESS_W   = 21;
    localparam int DT_W      = 26;
    localparam int MUL_W     = 26;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int WIDE_W    = 42;
    localparam int ACC_W     = 64;
    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int PC_W      = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_SENS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_SENS    = 3'd5;

    // temperature thresholds in 0.01 C
    localparam logic signed [TEMP_W-1:0] WARM_LIMIT = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] COLD_LIMIT = -19'sd1500;

    // program addresses
    localparam logic [PC_W-1:0] PC_START     = 5'd0;
    localparam logic [PC_W-1:0] PC_PRESS     = 5'd4;
    localparam logic [PC_W-1:0] PC_PMUL      = 5'd13;
    localparam logic [PC_W-1:0] PC_LAST      = 5'd17;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_RUN  = 2'b10
    } seq_state_t;

    // multiplier operand pair
    typedef enum logic [3:0] {
        MSEL_NONE,
        MSEL_DT_C6,
        MSEL_C4_DT,
        MSEL_C3_DT,
        MSEL_DT_DT,
        MSEL_T_T,
        MSEL_U_U,
        MSEL_RAW_HI,
        MSEL_RAW_LO
    } msel_t;

    // datapath operation
    typedef enum logic [3:0] {
        AOP_NOP,
        AOP_DT,
        AOP_TEMP1,
        AOP_OFF,
        AOP_SENS,
        AOP_T2,
        AOP_Q5,
        AOP_CORR1,
        AOP_Q7,
        AOP_CORR2A,
        AOP_CORR2B,
        AOP_P_HI,
        AOP_P_LO,
        AOP_P_OFF,
        AOP_EMIT
    } aop_t;

    // sequencing
    typedef enum logic [2:0] {
        JC_NEXT,
        JC_PRESS,
        JC_WARM,
        JC_MILD,
        JC_DONE
    } jc_t;

    typedef struct packed {
        msel_t            msel;
        aop_t             aop;
        jc_t              jc;
        logic [PC_W-1:0]  target;
    } ctrl_t;

    function automatic ctrl_t seq_rom(input logic [PC_W-1:0] pc);
        ctrl_t c;
        c = '{msel: MSEL_NONE, aop: AOP_NOP, jc: JC_DONE, target: PC_START};
        unique case (pc)
            // temperature word
            5'd0:  c = '{MSEL_NONE,   AOP_NOP,    JC_PRESS, PC_PRESS};
            5'd1:  c = '{MSEL_NONE,   AOP_DT,     JC_NEXT,  PC_START};
            5'd2:  c = '{MSEL_DT_C6,  AOP_NOP,    JC_NEXT,  PC_START};
            5'd3:  c = '{MSEL_NONE,   AOP_TEMP1,  JC_DONE,  PC_START};
            // pressure word
            5'd4:  c = '{MSEL_C4_DT,  AOP_NOP,    JC_NEXT,  PC_START};
            5'd5:  c = '{MSEL_C3_DT,  AOP_OFF,    JC_NEXT,  PC_START};
            5'd6:  c = '{MSEL_DT_DT,  AOP_SENS,   JC_WARM,  PC_PMUL};
            5'd7:  c = '{MSEL_T_T,    AOP_T2,     JC_NEXT,  PC_START};
            5'd8:  c = '{MSEL_U_U,    AOP_Q5,     JC_NEXT,  PC_START};
            5'd9:  c = '{MSEL_NONE,   AOP_CORR1,  JC_MILD,  PC_PMUL};
            5'd10: c = '{MSEL_NONE,   AOP_Q7,     JC_NEXT,  PC_START};
            5'd11: c = '{MSEL_NONE,   AOP_CORR2A, JC_NEXT,  PC_START};
            5'd12: c = '{MSEL_NONE,   AOP_CORR2B, JC_NEXT,  PC_START};
            5'd13: c = '{MSEL_RAW_HI, AOP_NOP,    JC_NEXT,  PC_START};
            5'd14: c = '{MSEL_RAW_LO, AOP_P_HI,   JC_NEXT,  PC_START};
            5'd15: c = '{MSEL_NONE,   AOP_P_LO,   JC_NEXT,  PC_START};
            5'd16: c = '{MSEL_NONE,   AOP_P_OFF,  JC_NEXT,  PC_START};
            5'd17: c = '{MSEL_NONE,   AOP_EMIT,   JC_DONE,  PC_START};
            default: c = '{MSEL_NONE, AOP_NOP,    JC_DONE,  PC_START};
        endcase
        return c;
    endfunction

endpackage

FILE: src/baro_pressure_temp_compensation.sv
// Top level: microcoded barometric temperature and pressure compensation.
//
// Takes one raw 24-bit converter word at a time. A temperature word (cmd 0)
// updates the stored dT and first-order temperature and gives no result. A
// pressure word (cmd 1) gives one result word with corrected temperature
// (0.01 C) and pressure (Pa), both saturated; the second-order correction is
// skipped at or above 20.00 C and gains a further term below -15.00 C. The
// control program runs every product through one shared 26x26 signed
// multiplier; s_ready is high whenever no word is in work, and a finished
// result sits in the output register, so the next word can be taken while it
// waits. If the previous result has not been taken, the final step holds
// until it is. Calibration words C1..C6 must be written through cfg_wr_* at
// indexes 0..5 only while idle, which the block itself does not enforce;
// other indexes are ignored.
module baro_pressure_temp_compensation (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [bptc_pkg::CFG_IDX_W-1:0]        cfg_wr_index,
    input  logic [bptc_pkg::COEF_W-1:0]           cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_cmd,
    input  logic [bptc_pkg::RAW_W-1:0]            s_raw_sample,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [bptc_pkg::TEMP_W-1:0]    m_temperature,
    output logic signed [bptc_pkg::PRESS_W-1:0]   m_pressure
);

    localparam int TW = bptc_pkg::TEMP_W;
    localparam int PW = bptc_pkg::PRESS_W;
    localparam int MW = bptc_pkg::MUL_W;
    localparam int QW = bptc_pkg::PROD_W;
    localparam int WW = bptc_pkg::WIDE_W;
    localparam int AW = bptc_pkg::ACC_W;

    // calibration words
    logic [bptc_pkg::COEF_W-1:0] coef_reg [bptc_pkg::NUM_REGS];

    // sequencer
    bptc_pkg::seq_state_t        state_reg, state_next;
    logic [bptc_pkg::PC_W-1:0]   pc_reg, pc_next;
    bptc_pkg::ctrl_t             ctrl;
    logic                        step_en;
    logic                        emit_fire;
    logic                        take_cond;

    // input word
    logic                        cmd_reg;
    logic [bptc_pkg::RAW_W-1:0]  raw_reg;

    // persistent state
    logic signed [bptc_pkg::DT_W-1:0] dt_reg, dt_next;
    logic signed [TW-1:0]             ftemp_reg, ftemp_next;

    // datapath scratch
    logic signed [MW-1:0]  mul_a, mul_b;
    logic signed [QW-1:0]  prod_reg, prod_next;
    logic signed [WW-1:0]  off_reg, off_next;
    logic signed [WW-1:0]  sens_reg, sens_next;
    logic signed [WW-1:0]  q_reg, q_next;
    logic signed [WW-1:0]  prod_w;
    logic [17:0]           t2_reg, t2_next;
    logic signed [AW-1:0]  acc_reg, acc_next;

    // output
    logic                  m_valid_reg, m_valid_next;
    logic signed [TW-1:0]  m_temp_reg, m_temp_next;
    logic signed [PW-1:0]  m_press_reg, m_press_next;

    // intermediate values
    logic signed [MW-1:0]  ftemp_ext;
    logic signed [29:0]    temp1_sum;
    logic signed [TW:0]    tcorr;
    logic signed [AW-1:0]  press_sh;

    assign s_ready       = (state_reg == bptc_pkg::SEQ_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_temperature = m_temp_reg;
    assign m_pressure    = m_press_reg;

    assign ctrl      = bptc_pkg::seq_rom(pc_reg);
    // hold the last step while the previous result is still waiting
    assign step_en   = (state_reg == bptc_pkg::SEQ_RUN) &&
                       !(ctrl.aop == bptc_pkg::AOP_EMIT && m_valid_reg && !m_ready);
    assign emit_fire = step_en && (ctrl.aop == bptc_pkg::AOP_EMIT);
    assign ftemp_ext = MW'(ftemp_reg);
    assign prod_w    = WW'(prod_reg);

    // jump condition select
    always_comb begin
        unique case (ctrl.jc)
            bptc_pkg::JC_PRESS: take_cond = cmd_reg;
            bptc_pkg::JC_WARM:  take_cond = (ftemp_reg >= bptc_pkg::WARM_LIMIT);
            bptc_pkg::JC_MILD:  take_cond = (ftemp_reg >= bptc_pkg::COLD_LIMIT);
            default:            take_cond = 1'b0;
        endcase
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        if (state_reg == bptc_pkg::SEQ_IDLE) begin
            if (s_valid) begin
                state_next = bptc_pkg::SEQ_RUN;
                pc_next    = bptc_pkg::PC_START;
            end
        end else if (step_en) begin
            if (ctrl.jc == bptc_pkg::JC_DONE) begin
                state_next = bptc_pkg::SEQ_IDLE;
            end else if (take_cond) begin
                pc_next = ctrl.target;
            end else begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.msel)
            bptc_pkg::MSEL_DT_C6: begin
                mul_a = MW'(dt_reg);
                mul_b = $signed({{(MW-bptc_pkg::COEF_W){1'b0}},
                                 coef_reg[bptc_pkg::REG_TEMP_SENS]});
            end
            bptc_pkg::MSEL_C4_DT: begin
                mul_a = MW'(dt_reg);
                mul_b = $signed({{(MW-bptc_pkg::COEF_W){1'b0}},
                                 coef_reg[bptc_pkg::REG_OFFSET_TEMP]});
            end
            bptc_pkg::MSEL_C3_DT: begin
                mul_a = MW'(dt_reg);
                mul_b = $signed({{(MW-bptc_pkg::COEF_W){1'b0}},
                                 coef_reg[bptc_pkg::REG_SENS_TEMP]});
            end
            bptc_pkg::MSEL_DT_DT: begin
                mul_a = MW'(dt_reg);
                mul_b = MW'(dt_reg);
            end
            bptc_pkg::MSEL_T_T: begin
                mul_a = ftemp_ext - MW'(bptc_pkg::WARM_LIMIT);
                mul_b = ftemp_ext - MW'(bptc_pkg::WARM_LIMIT);
            end
            bptc_pkg::MSEL_U_U: begin
                mul_a = ftemp_ext - MW'(bptc_pkg::COLD_LIMIT);
                mul_b = ftemp_ext - MW'(bptc_pkg::COLD_LIMIT);
            end
            bptc_pkg::MSEL_RAW_HI: begin
                // upper part of SENS, signed
                mul_a = $signed({{(MW-bptc_pkg::RAW_W){1'b0}}, raw_reg});
                mul_b = MW'($signed(sens_reg[WW-1:20]));
            end
            bptc_pkg::MSEL_RAW_LO: begin
                // lower 20 bits of SENS, unsigned
                mul_a = $signed({{(MW-bptc_pkg::RAW_W){1'b0}}, raw_reg});
                mul_b = $signed({{(MW-20){1'b0}}, sens_reg[19:0]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = (step_en && ctrl.msel != bptc_pkg::MSEL_NONE) ?
                       (mul_a * mul_b) : prod_reg;

    // datapath operations
    always_comb begin
        dt_next      = dt_reg;
        ftemp_next   = ftemp_reg;
        off_next     = off_reg;
        sens_next    = sens_reg;
        q_next       = q_reg;
        t2_next      = t2_reg;
        acc_next     = acc_reg;
        m_temp_next  = m_temp_reg;
        m_press_next = m_press_reg;
        temp1_sum    = 30'(prod_reg >>> 23) + 30'sd2000;
        tcorr        = $signed({ftemp_reg[TW-1], ftemp_reg}) - $signed({2'b00, t2_reg});
        press_sh     = acc_reg >>> 15;
        if (step_en) begin
            unique case (ctrl.aop)
                bptc_pkg::AOP_DT: begin
                    dt_next = $signed({2'b00, raw_reg}) -
                              $signed({2'b00, coef_reg[bptc_pkg::REG_REF_TEMP], 8'h00});
                end
                bptc_pkg::AOP_TEMP1: begin
                    if (temp1_sum > 30'sd262143) begin
                        ftemp_next = {1'b0, {(TW-1){1'b1}}};
                    end else if (temp1_sum < -30'sd262144) begin
                        ftemp_next = {1'b1, {(TW-1){1'b0}}};
                    end else begin
                        ftemp_next = TW'(temp1_sum);
                    end
                end
                bptc_pkg::AOP_OFF: begin
                    off_next = $signed({10'b0, coef_reg[bptc_pkg::REG_PRESS_OFFSET], 16'h0000})
                               + WW'(prod_reg >>> 7);
                end
                bptc_pkg::AOP_SENS: begin
                    sens_next = $signed({11'b0, coef_reg[bptc_pkg::REG_PRESS_SENS], 15'h0000})
                                + WW'(prod_reg >>> 8);
                    t2_next   = '0;
                end
                bptc_pkg::AOP_T2: begin
                    t2_next = prod_reg[48:31];
                end
                bptc_pkg::AOP_Q5: begin
                    q_next = prod_w + (prod_w <<< 2);
                end
                bptc_pkg::AOP_CORR1: begin
                    off_next  = off_reg - (q_reg >>> 1);
                    sens_next = sens_reg - (q_reg >>> 2);
                end
                bptc_pkg::AOP_Q7: begin
                    q_next = (prod_w <<< 3) - prod_w;
                end
                bptc_pkg::AOP_CORR2A: begin
                    off_next = off_reg - q_reg;
                    q_next   = (prod_w <<< 3) + (prod_w <<< 1) + prod_w;
                end
                bptc_pkg::AOP_CORR2B: begin
                    sens_next = sens_reg - (q_reg >>> 1);
                end
                bptc_pkg::AOP_P_HI: begin
                    acc_next = AW'(prod_reg) <<< 20;
                end
                bptc_pkg::AOP_P_LO: begin
                    acc_next = acc_reg + AW'(prod_reg);
                end
                bptc_pkg::AOP_P_OFF: begin
                    acc_next = (acc_reg >>> 21) - AW'(off_reg);
                end
                bptc_pkg::AOP_EMIT: begin
                    if (tcorr > 20'sd262143) begin
                        m_temp_next = {1'b0, {(TW-1){1'b1}}};
                    end else if (tcorr < -20'sd262144) begin
                        m_temp_next = {1'b1, {(TW-1){1'b0}}};
                    end else begin
                        m_temp_next = TW'(tcorr);
                    end
                    if (press_sh > 64'sd1048575) begin
                        m_press_next = {1'b0, {(PW-1){1'b1}}};
                    end else if (press_sh < -64'sd1048576) begin
                        m_press_next = {1'b1, {(PW-1){1'b0}}};
                    end else begin
                        m_press_next = PW'(press_sh);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid_next = (m_valid_reg && !m_ready) || emit_fire;

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bptc_pkg::SEQ_IDLE;
            pc_reg      <= bptc_pkg::PC_START;
            m_valid_reg <= 1'b0;
            dt_reg      <= '0;
            ftemp_reg   <= '0;
            for (int i = 0; i < bptc_pkg::NUM_REGS; i++) begin
                coef_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
            dt_reg      <= dt_next;
            ftemp_reg   <= ftemp_next;
            if (cfg_wr_en && (32'(cfg_wr_index) < bptc_pkg::NUM_REGS)) begin
                coef_reg[cfg_wr_index] <= cfg_wr_data;
            end
        end
    end

    // payload and scratch registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_cmd;
            raw_reg <= s_raw_sample;
        end
        prod_reg    <= prod_next;
        off_reg     <= off_next;
        sens_reg    <= sens_next;
        q_reg       <= q_next;
        t2_reg      <= t2_next;
        acc_reg     <= acc_next;
        m_temp_reg  <= m_temp_next;
        m_press_reg <= m_press_next;
    end

    // program counter never leaves the program while running
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bptc_pkg::SEQ_RUN) |-> (pc_reg <= bptc_pkg::PC_LAST))
        else $error("pc outside program");

    // a result is written only into a free output slot
    a_emit_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |-> (!m_valid_reg || m_ready))
        else $error("result overwrote pending word");

    // dT changes only in its own step
    a_dt_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(step_en && ctrl.aop == bptc_pkg::AOP_DT) |=> $stable(dt_reg))
        else $error("dT changed outside its step");

    // a temperature word gives no result
    a_temp_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_cmd) |=>
            !$rose(m_valid_reg) ##1 !$rose(m_valid_reg) ##1
            !$rose(m_valid_reg) ##1 !$rose(m_valid_reg) ##1 !$rose(m_valid_reg))
        else $error("temperature word produced a result");

endmodule

FILE: bench/tb_top.sv
// Testbench for the barometric compensation block: reference scoreboard and directed/random stimulus.
module tb_top;
    import bptc_pkg::*;

    // sample tags on s_cmd
    localparam logic CMD_TEMP  = 1'b0;
    localparam logic CMD_PRESS = 1'b1;

    // reference point and cold threshold of the second-order correction, 0.01 C
    localparam longint T_REF  = 2000;
    localparam longint T_COLD = -1500;

    // saturation bounds of the result fields
    localparam longint TEMP_LO  = -(longint'(1) << (TEMP_W - 1));
    localparam longint TEMP_HI  = (longint'(1) << (TEMP_W - 1)) - 1;
    localparam longint PRESS_LO = -(longint'(1) << (PRESS_W - 1));
    localparam longint PRESS_HI = (longint'(1) << (PRESS_W - 1)) - 1;

    localparam int REPORT_MAX = 10;

    // Scoreboard: mirrors calibration and the stored temperature state,
    // predicts each result word and checks them in order.
    class reading_board;
        typedef struct packed {
            logic signed [TEMP_W-1:0]  temp;
            logic signed [PRESS_W-1:0] press;
        } reading_t;

        longint   coef [NUM_REGS];
        longint   temp_delta;
        longint   first_temp;
        reading_t readings_due [$];
        int       mismatches;

        function new();
            foreach (coef[i]) coef[i] = 0;
            temp_delta = 0;
            first_temp = 0;
            mismatches = 0;
        endfunction

        function void write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
            if (idx < NUM_REGS) coef[idx] = val;
        endfunction

        function longint sat(longint v, longint lo, longint hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        // accepted input word: update state, or predict one reading
        function void take_sample(logic cmd, logic [RAW_W-1:0] raw);
            longint   r, dt, tmp, off, sens, off2, sens2, t2, d, tc, p;
            reading_t e;
            r = raw;
            if (cmd == CMD_TEMP) begin
                dt = r - (coef[REG_REF_TEMP] << 8);
                tmp = T_REF + ((dt * coef[REG_TEMP_SENS]) >>> 23);
                temp_delta = dt;
                first_temp = sat(tmp, TEMP_LO, TEMP_HI);
                return;
            end
            dt   = temp_delta;
            tmp  = first_temp;
            off  = (coef[REG_PRESS_OFFSET] << 16) + ((coef[REG_OFFSET_TEMP] * dt) >>> 7);
            sens = (coef[REG_PRESS_SENS] << 15) + ((coef[REG_SENS_TEMP] * dt) >>> 8);
            t2    = 0;
            off2  = 0;
            sens2 = 0;
            if (tmp < T_REF) begin
                t2    = (dt * dt) >>> 31;
                d     = (tmp - T_REF) * (tmp - T_REF);
                off2  = (5 * d) >>> 1;
                sens2 = (5 * d) >>> 2;
                if (tmp < T_COLD) begin
                    d     = (tmp - T_COLD) * (tmp - T_COLD);
                    off2  = off2 + 7 * d;
                    sens2 = sens2 + ((11 * d) >>> 1);
                end
            end
            tc = sat(tmp - t2, TEMP_LO, TEMP_HI);
            p  = sat((((r * (sens - sens2)) >>> 21) - (off - off2)) >>> 15, PRESS_LO, PRESS_HI);
            e.temp  = tc[TEMP_W-1:0];
            e.press = p[PRESS_W-1:0];
            readings_due.push_back(e);
        endfunction

        // accepted result word: compare against the oldest prediction
        function void check_reading(logic signed [TEMP_W-1:0] t, logic signed [PRESS_W-1:0] p);
            reading_t e;
            if (readings_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result word: temperature %0d pressure %0d",
                             $signed(t), $signed(p));
                return;
            end
            e = readings_due.pop_front();
            if (t !== e.temp || p !== e.press) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result mismatch: temperature exp %0d got %0d, pressure exp %0d got %0d",
                             $signed(e.temp), $signed(t), $signed(e.press), $signed(p));
            end
        endfunction
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_wr_index = '0;
    logic [COEF_W-1:0]          cfg_wr_data = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_cmd = 1'b0;
    logic [RAW_W-1:0]           s_raw_sample = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [TEMP_W-1:0]   m_temperature;
    logic signed [PRESS_W-1:0]  m_pressure;

    // percent of cycles in which the sender idles / the receiver stalls
    int src_gap_pct    = 35;
    int sink_stall_pct = 35;

    reading_board board;

    baro_pressure_temp_compensation dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_raw_sample  (s_raw_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_temperature (m_temperature),
        .m_pressure    (m_pressure)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Receiver: values seen here are those sampled at this edge; m_ready for
    // the next edge is picked at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) board.check_reading(m_temperature, m_pressure);
            m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // One calibration write, taken at the next edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        board.write_coef(idx, val);
    endtask

    // Full calibration set plus one write to an unused index, which must be ignored.
    task automatic load_coefs(input logic [COEF_W-1:0] c1, input logic [COEF_W-1:0] c2,
                              input logic [COEF_W-1:0] c3, input logic [COEF_W-1:0] c4,
                              input logic [COEF_W-1:0] c5, input logic [COEF_W-1:0] c6);
        write_reg(REG_PRESS_SENS, c1);
        write_reg(REG_PRESS_OFFSET, c2);
        write_reg(REG_SENS_TEMP, c3);
        write_reg(REG_OFFSET_TEMP, c4);
        write_reg(REG_REF_TEMP, c5);
        write_reg(REG_TEMP_SENS, c6);
        write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
                  COEF_W'($urandom_range(0, 16'hFFFF)));
        cfg_wr_en <= 1'b0;
    endtask

    // Send one word; valid holds with a fixed payload until the handshake.
    task automatic send_word(input logic cmd, input logic [RAW_W-1:0] raw);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_raw_sample <= raw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.take_sample(cmd, raw);
    endtask

    // Drop valid, let every predicted reading drain, then allow for a
    // temperature word still in work.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (board.readings_due.size() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    // Pressure sample: mostly full-range random, some rail values.
    function automatic logic [RAW_W-1:0] press_raw();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? {RAW_W{1'b1}} : '0;
        return RAW_W'($urandom);
    endfunction

    // Random phase: mostly a temperature word followed by one to three
    // pressure words; the rest are lone words of either kind.
    task automatic run_phase(input int n_words, input bit hold);
        int done, kind, reps, mag, base, raw_i;
        bit held;
        done = 0;
        held = 0;
        base = int'(board.coef[REG_REF_TEMP]) * 256;
        while (done < n_words) begin
            if (hold && !held && done >= n_words / 2) begin
                // sender holds off until all readings are back
                wait_idle();
                held = 1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                // dT of random magnitude around the reference point hits all three bands
                mag   = $urandom_range(0, RAW_W);
                raw_i = int'($urandom_range(0, (1 << mag) - 1));
                raw_i = $urandom_range(0, 1) ? base + raw_i : base - raw_i;
                if (raw_i < 0) raw_i = 0;
                if (raw_i > (1 << RAW_W) - 1) raw_i = (1 << RAW_W) - 1;
                if ($urandom_range(0, 7) == 0) raw_i = int'($urandom_range(0, (1 << RAW_W) - 1));
                send_word(CMD_TEMP, raw_i[RAW_W-1:0]);
                reps = $urandom_range(1, 3);
                repeat (reps) send_word(CMD_PRESS, press_raw());
                done += 1 + reps;
            end else if (kind < 88) begin
                send_word(CMD_PRESS, press_raw());
                done++;
            end else begin
                send_word(CMD_TEMP, RAW_W'($urandom));
                done++;
            end
        end
    endtask

    initial begin
        board = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // pressure before any temperature word: reset state, mild cold band with dT = 0
        send_word(CMD_PRESS, '0);
        send_word(CMD_PRESS, {RAW_W{1'b1}});

        // typical calibration: warm, mild cold and very cold bands, repeated pressure
        wait_idle();
        load_coefs(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        send_word(CMD_TEMP, 24'd8569150);
        send_word(CMD_PRESS, 24'd9085466);
        send_word(CMD_PRESS, 24'd9085466);
        send_word(CMD_TEMP, 24'd8270494);
        send_word(CMD_PRESS, 24'd9085466);
        send_word(CMD_PRESS, '0);
        send_word(CMD_TEMP, '0);
        send_word(CMD_PRESS, {RAW_W{1'b1}});
        send_word(CMD_PRESS, 24'd9085466);
        send_word(CMD_PRESS, 24'd9085466);
        send_word(CMD_TEMP, {RAW_W{1'b1}});
        send_word(CMD_PRESS, 24'd9085466);

        // all coefficients at max: deep cold, pressure saturates both ways
        wait_idle();
        load_coefs('1, '1, '1, '1, '1, '1);
        send_word(CMD_TEMP, '0);
        send_word(CMD_PRESS, {RAW_W{1'b1}});
        send_word(CMD_PRESS, '0);

        // large sensitivity, max dT: pressure saturates high
        wait_idle();
        load_coefs('1, '0, '1, '0, '0, '1);
        send_word(CMD_TEMP, {RAW_W{1'b1}});
        send_word(CMD_PRESS, {RAW_W{1'b1}});
        send_word(CMD_PRESS, '0);

        // large offset terms only
        wait_idle();
        load_coefs('0, '1, '0, '1, '0, '1);
        send_word(CMD_TEMP, {RAW_W{1'b1}});
        send_word(CMD_PRESS, '0);

        // random phases over several calibrations
        wait_idle();
        load_coefs(COEF_W'($urandom_range(0, 16'hFFFF)), COEF_W'($urandom_range(0, 16'hFFFF)),
                   COEF_W'($urandom_range(0, 16'hFFFF)), COEF_W'($urandom_range(0, 16'hFFFF)),
                   COEF_W'($urandom_range(0, 16'hFFFF)), COEF_W'($urandom_range(0, 16'hFFFF)));
        run_phase(160, 0);

        // near-typical calibration, no idling on either side
        wait_idle();
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        load_coefs(COEF_W'(40127 + $urandom_range(0, 255)),
                   COEF_W'(36924 + $urandom_range(0, 255)),
                   COEF_W'(23317 + $urandom_range(0, 255)),
                   COEF_W'(23282 + $urandom_range(0, 255)),
                   COEF_W'(33464 + $urandom_range(0, 255)),
                   COEF_W'(28312 + $urandom_range(0, 255)));
        run_phase(160, 0);

        wait_idle();
        src_gap_pct    = 35;
        sink_stall_pct = 35;
        load_coefs('1, '1, '1, '1, '1, '1);
        run_phase(150, 0);

        wait_idle();
        load_coefs('0, '0, '0, '0, '0, '0);
        run_phase(150, 0);

        wait_idle();
        load_coefs(COEF_W'($urandom_range(0, 16'hFFFF)), COEF_W'($urandom_range(0, 16'hFFFF)),
                   COEF_W'($urandom_range(0, 16'hFFFF)), COEF_W'($urandom_range(0, 16'hFFFF)),
                   COEF_W'($urandom_range(0, 16'hFFFF)), COEF_W'($urandom_range(0, 16'hFFFF)));
        run_phase(170, 1);

        // small temperature slope keeps the first-order temperature near 20 C
        wait_idle();
        load_coefs(COEF_W'($urandom_range(0, 16'hFFFF)), COEF_W'($urandom_range(0, 16'hFFFF)),
                   COEF_W'($urandom_range(0, 16'hFFFF)), COEF_W'($urandom_range(0, 16'hFFFF)),
                   COEF_W'($urandom_range(0, 16'hFFFF)), COEF_W'($urandom_range(0, 255)));
        run_phase(160, 0);

        wait_idle();
        if (board.mismatches == 0 && board.readings_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
src/bptc_pkg.sv
src/baro_pressure_temp_compensation.sv
bench/tb_top.sv
